// ===== hdl/qdsa_pkg.sv =====
// ============================================================================
// qdsa_pkg
// Shared types and constants for the quad diode sun angle core.
// ============================================================================
package qdsa_pkg;

    localparam int unsigned RegBits = 16;
    localparam int unsigned CfgIdxBits = 3;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_WEIGHT_ONE   = 3'd0,
        REG_WEIGHT_TWO   = 3'd1,
        REG_WEIGHT_THREE = 3'd2,
        REG_WEIGHT_FOUR  = 3'd3,
        REG_GAIN         = 3'd4
    } t_reg_idx;

    // back unit sequencing
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT, S_OUT} t_bstate;

    typedef struct packed {
        logic [15:0] current_one;
        logic [15:0] current_two;
        logic [15:0] current_three;
        logic [15:0] current_four;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] x_position;
        logic signed [15:0] y_position;
        logic [15:0]        off_angle;
        logic               zero_sum;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        logic [15:0] w4;
        logic [15:0] gain;
    } t_cfg;

endpackage

// ===== hdl/qdsa_front.sv =====
// ============================================================================
// qdsa_front
// Masks currents, forms weighted sums, differences, gain products and the
// divisor. Two register stages; one item per cycle.
// ============================================================================
module qdsa_front
    import qdsa_pkg::*;
#(
    parameter int unsigned CurBits = 16,
    parameter int unsigned NumBits = CurBits + 35,
    parameter int unsigned DenBits = CurBits + 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_item           i_item,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic [NumBits-1:0] o_mag_x,
    output logic               o_neg_x,
    output logic [NumBits-1:0] o_mag_y,
    output logic               o_neg_y,
    output logic [DenBits-1:0] o_den,
    output logic               o_zero
);
    localparam int unsigned TBits = CurBits + 16;
    localparam int unsigned PBits = TBits + 1;

    logic [CurBits-1:0] c1, c2, c3, c4;
    logic [CurBits+1:0] sum;
    assign c1  = CurBits'(i_item.current_one);
    assign c2  = CurBits'(i_item.current_two);
    assign c3  = CurBits'(i_item.current_three);
    assign c4  = CurBits'(i_item.current_four);
    assign sum = {2'b0, c1} + {2'b0, c2} + {2'b0, c3} + {2'b0, c4};

    // stage 1: weighted terms
    logic [TBits-1:0]   r_t1, r_t2, r_t3, r_t4;
    logic [CurBits+1:0] r_sum;
    logic               r_v1;
    always_ff @(posedge i_clk) begin
        r_t1  <= TBits'(c1) * TBits'(i_cfg.w1);
        r_t2  <= TBits'(c2) * TBits'(i_cfg.w2);
        r_t3  <= TBits'(c3) * TBits'(i_cfg.w3);
        r_t4  <= TBits'(c4) * TBits'(i_cfg.w4);
        r_sum <= sum;
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_valid;
    end

    // differences as sign and magnitude
    logic [PBits-1:0] px, nx, py, ny, dx, dy;
    assign px = {1'b0, r_t2} + {1'b0, r_t3};
    assign nx = {1'b0, r_t1} + {1'b0, r_t4};
    assign py = {1'b0, r_t1} + {1'b0, r_t2};
    assign ny = {1'b0, r_t3} + {1'b0, r_t4};
    assign dx = (px >= nx) ? px - nx : nx - px;
    assign dy = (py >= ny) ? py - ny : ny - py;

    // stage 2: gain product, rounding offset folded in
    always_ff @(posedge i_clk) begin
        o_mag_x <= NumBits'(dx) * NumBits'(i_cfg.gain)
                   + NumBits'({r_sum, 11'b0});
        o_mag_y <= NumBits'(dy) * NumBits'(i_cfg.gain)
                   + NumBits'({r_sum, 11'b0});
        o_neg_x <= px < nx;
        o_neg_y <= py < ny;
        o_den   <= DenBits'({r_sum, 12'b0});
        o_zero  <= r_sum == '0;
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v1;
    end
endmodule

// ===== hdl/qdsa_back.sv =====
// ============================================================================
// qdsa_back
// Iterative divider for x and y, then iterative square root and saturation.
// One item at a time, handshake to the FIFO in front and output queue after.
// ============================================================================
module qdsa_back
    import qdsa_pkg::*;
#(
    parameter int unsigned NumBits = 51,
    parameter int unsigned DenBits = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [NumBits-1:0] i_mag_x,
    input  logic               i_neg_x,
    input  logic [NumBits-1:0] i_mag_y,
    input  logic               i_neg_y,
    input  logic [DenBits-1:0] i_den,
    input  logic               i_zero,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_item          o_item
);
    localparam int unsigned CntBits = $clog2(NumBits + 1);
    localparam int unsigned RemBits = DenBits + 1;

    t_bstate r_st, n_st;

    logic [NumBits-1:0] r_qx, r_qy;
    logic [RemBits-1:0] r_rx, r_ry;
    logic [DenBits-1:0] r_den;
    logic               r_nx, r_ny, r_zero;
    logic [CntBits-1:0] r_cnt;
    // root state
    logic [33:0]        r_rv;
    logic [33:0]        r_res;
    logic [33:0]        r_bit;

    logic [RemBits-1:0] tx, ty;
    assign tx = {r_rx[DenBits-1:0], r_qx[NumBits-1]};
    assign ty = {r_ry[DenBits-1:0], r_qy[NumBits-1]};

    logic [16:0] lx, ly;
    assign lx = (r_qx > NumBits'(65536)) ? 17'd65536 : r_qx[16:0];
    assign ly = (r_qy > NumBits'(65536)) ? 17'd65536 : r_qy[16:0];

    logic [33:0] rb;
    assign rb = r_res + r_bit;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid) n_st = i_zero ? S_OUT : S_DIV;
            S_DIV:   if (r_cnt == CntBits'(1)) n_st = S_ROOT;
            S_ROOT:  if (r_bit == '0) n_st = S_OUT;
            S_OUT:   if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_st)
            S_IDLE:  o_ready = 1'b1;
            S_OUT:   o_valid = 1'b1;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (i_valid) begin
                r_qx <= i_mag_x; r_qy <= i_mag_y;
                r_rx <= '0; r_ry <= '0;
                r_den <= i_den; r_nx <= i_neg_x; r_ny <= i_neg_y;
                r_zero <= i_zero;
                r_cnt <= CntBits'(NumBits);
            end
            S_DIV: begin
                // one restoring-division bit per cycle on each axis
                if (tx >= {1'b0, r_den}) begin
                    r_rx <= tx - {1'b0, r_den};
                    r_qx <= {r_qx[NumBits-2:0], 1'b1};
                end else begin
                    r_rx <= tx;
                    r_qx <= {r_qx[NumBits-2:0], 1'b0};
                end
                if (ty >= {1'b0, r_den}) begin
                    r_ry <= ty - {1'b0, r_den};
                    r_qy <= {r_qy[NumBits-2:0], 1'b1};
                end else begin
                    r_ry <= ty;
                    r_qy <= {r_qy[NumBits-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                r_bit <= 34'h1 << 32;
                r_res <= '0;
            end
            S_ROOT: begin
                if (r_bit == 34'h1 << 32 && r_res == '0 && r_cnt == '0) begin
                    r_rv  <= 34'(lx) * 34'(lx) + 34'(ly) * 34'(ly);
                    r_cnt <= CntBits'(1);
                end else if (r_bit != '0) begin
                    // one result bit per cycle
                    if (r_rv >= rb) begin
                        r_rv  <= r_rv - rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    // remainder > root means round up
                    if (r_rv > r_res) r_res <= r_res + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // saturation on the output fields
    logic cx, cy, ca;
    assign cx = r_nx ? (r_qx > NumBits'(32768)) : (r_qx > NumBits'(32767));
    assign cy = r_ny ? (r_qy > NumBits'(32768)) : (r_qy > NumBits'(32767));
    assign ca = r_res > 34'd65535;

    logic [15:0] xm, ym;
    assign xm = cx ? (r_nx ? 16'h8000 : 16'h7fff) : r_qx[15:0];
    assign ym = cy ? (r_ny ? 16'h8000 : 16'h7fff) : r_qy[15:0];

    always_comb begin
        if (r_zero) begin
            o_item = '0;
            o_item.zero_sum = 1'b1;
        end else begin
            o_item.x_position = r_nx ? 16'(-xm) : xm;
            o_item.y_position = r_ny ? 16'(-ym) : ym;
            o_item.off_angle  = ca ? 16'hffff : r_res[15:0];
            o_item.zero_sum   = 1'b0;
            o_item.saturated  = cx | cy | ca;
        end
    end
endmodule

// ===== hdl/quad_diode_sun_angle_core.sv =====
// ============================================================================
// quad_diode_sun_angle_core
// Sun offset x, y and off-sun angle from four photodiode currents.
// ============================================================================
// Input queue side: push a current set while full is low. Result queue side:
// the oldest result sits on o_result while empty is low; pop to take it.
// Config writes (index, data) transfer on valid and ready; ready is always
// high, and writes should only be made while the block is idle.
// A front pipeline (two stages, multipliers) feeds a four-entry queue;
// the back unit runs one restoring divider bit per cycle for x and y
// and then the square root (load, one bit per cycle, round); it takes
// one item at a time through its idle, divide, root and output states,
// so the back unit sets the throughput.
// Results wait in a two-entry output queue; when the receiver stalls, the
// back unit stops and the input queue fills until full rises.
// Reset (synchronous, active low) empties all queues and loads unit
// weights and unit gain.
module quad_diode_sun_angle_core
    import qdsa_pkg::*;
#(
    parameter int unsigned CURRENT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [RegBits-1:0]    i_cfg_data
);
    localparam int unsigned NumBits = CURRENT_BITS + 35;
    localparam int unsigned DenBits = CURRENT_BITS + 14;
    localparam int unsigned QW = 2 * NumBits + 3 + DenBits;

    t_cfg r_cfg;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd4096};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WEIGHT_ONE:   r_cfg.w1   <= i_cfg_data;
                REG_WEIGHT_TWO:   r_cfg.w2   <= i_cfg_data;
                REG_WEIGHT_THREE: r_cfg.w3   <= i_cfg_data;
                REG_WEIGHT_FOUR:  r_cfg.w4   <= i_cfg_data;
                REG_GAIN:         r_cfg.gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the front never stalls; its results land in a queue with room for
    // everything in flight, so full counts pipeline items too
    logic               f_v, f_nx, f_ny, f_z;
    logic [NumBits-1:0] f_mx, f_my;
    logic [DenBits-1:0] f_den;
    logic               acc;
    assign acc = push & ~full;

    qdsa_front #(.CurBits(CURRENT_BITS), .NumBits(NumBits), .DenBits(DenBits)) u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_item, .i_cfg(r_cfg),
        .o_valid(f_v), .o_mag_x(f_mx), .o_neg_x(f_nx), .o_mag_y(f_my),
        .o_neg_y(f_ny), .o_den(f_den), .o_zero(f_z)
    );

    // four-entry queue between front and back
    logic [QW-1:0] r_q [4];
    logic [1:0]    r_wp, r_rp;
    logic [3:0]    r_cnt;     // queued plus in front pipeline
    logic [2:0]    r_qn;
    logic          b_rdy, b_take;
    assign b_take = b_rdy & (r_qn != '0);
    assign full   = r_cnt >= 4'd4;

    always_ff @(posedge i_clk) begin
        if (f_v) r_q[r_wp] <= {f_mx, f_nx, f_my, f_ny, f_den, f_z};
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_qn <= '0;
        end else begin
            if (f_v)    r_wp <= r_wp + 1'b1;
            if (b_take) r_rp <= r_rp + 1'b1;
            r_qn  <= r_qn + 3'(f_v) - 3'(b_take);
            r_cnt <= r_cnt + 4'(acc) - 4'(b_take);
        end
    end

    logic [QW-1:0] q_o;
    assign q_o = r_q[r_rp];

    logic      b_v, o_rdy;
    t_out_item b_item;
    qdsa_back #(.NumBits(NumBits), .DenBits(DenBits)) u_back (
        .i_clk, .i_rst_n, .i_valid(r_qn != '0), .o_ready(b_rdy),
        .i_mag_x(q_o[QW-1 -: NumBits]), .i_neg_x(q_o[QW-1-NumBits]),
        .i_mag_y(q_o[QW-2-NumBits -: NumBits]), .i_neg_y(q_o[DenBits+1]),
        .i_den(q_o[DenBits:1]), .i_zero(q_o[0]),
        .o_valid(b_v), .i_ready(o_rdy), .o_item(b_item)
    );

    // two-entry result queue
    t_out_item r_oq [2];
    logic      r_owp, r_orp;
    logic [1:0] r_on;
    logic      o_push, o_pop;
    assign o_rdy  = r_on != 2'd2;
    assign o_push = b_v & o_rdy;
    assign o_pop  = pop & ~empty;
    assign empty  = r_on == '0;
    assign o_result = r_oq[r_orp];
    always_ff @(posedge i_clk) begin
        if (o_push) r_oq[r_owp] <= b_item;
        if (!i_rst_n) begin
            r_owp <= 1'b0; r_orp <= 1'b0; r_on <= '0;
        end else begin
            if (o_push) r_owp <= ~r_owp;
            if (o_pop)  r_orp <= ~r_orp;
            r_on <= r_on + 2'(o_push) - 2'(o_pop);
        end
    end
endmodule

// ===== tb/sv/quad_diode_sun_angle_core_tb.sv =====
// ============================================================================
// quad_diode_sun_angle_core_tb
// Self-checking bench: drives current sets through the push side, predicts
// x, y, angle and flags in fixed point, and checks every popped result.
// ============================================================================
module quad_diode_sun_angle_core_tb;
    import qdsa_pkg::*;

    localparam int unsigned DrainCycles = 120;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    t_in_item        i_item = '0;
    logic            empty;
    logic            pop = 1'b0;
    t_out_item       o_result;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [CfgIdxBits-1:0] i_cfg_index = '0;
    logic [RegBits-1:0]    i_cfg_data = '0;

    t_cfg      sensor_cfg;
    t_out_item angle_queue[$];
    int        mismatch_count = 0;
    int        idle_enable = 1;
    int        hold_cycles = 0;

    quad_diode_sun_angle_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // round(gain*|pos-neg|/den), ties away from zero
    function automatic logic [63:0] scaled_diff(input logic [63:0] pos, input logic [63:0] neg,
                                                input logic [63:0] den, output bit negative);
        logic [63:0] mag;
        begin
            negative = pos < neg;
            mag = negative ? neg - pos : pos - neg;
            mag = mag * sensor_cfg.gain;
            return (mag + (den >> 1)) / den;
        end
    endfunction

    function automatic logic [15:0] clip_q14(input logic [63:0] mag, input bit negative,
                                             inout bit clipped);
        begin
            if (negative) begin
                if (mag > 32768) begin
                    mag = 32768;
                    clipped = 1;
                end
                return 16'(17'h10000 - mag[16:0]);
            end
            if (mag > 32767) begin
                mag = 32767;
                clipped = 1;
            end
            return mag[15:0];
        end
    endfunction

    function automatic t_out_item predict_sun_angle(input t_in_item it);
        t_out_item   res;
        logic [63:0] t1, t2, t3, t4, total, den, qx, qy, lx, ly, s, r;
        bit          nx, ny, clipped;
        begin
            res = '0;
            clipped = 0;
            total = 64'(it.current_one) + it.current_two + it.current_three + it.current_four;
            if (total == 0) begin
                res.zero_sum = 1'b1;
                return res;
            end
            t1 = 64'(sensor_cfg.w1) * it.current_one;
            t2 = 64'(sensor_cfg.w2) * it.current_two;
            t3 = 64'(sensor_cfg.w3) * it.current_three;
            t4 = 64'(sensor_cfg.w4) * it.current_four;
            den = total << 12;
            qx = scaled_diff(t2 + t3, t1 + t4, den, nx);
            qy = scaled_diff(t1 + t2, t3 + t4, den, ny);
            lx = qx > 65536 ? 64'd65536 : qx;
            ly = qy > 65536 ? 64'd65536 : qy;
            s = lx * lx + ly * ly;
            // integer square root by bisection, then round to nearest
            r = 0;
            for (int b = 17; b >= 0; b--) begin
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s)
                    r = r | (64'd1 << b);
            end
            if (s - r * r > r)
                r = r + 1;
            if (r > 65535) begin
                r = 65535;
                clipped = 1;
            end
            res.x_position = clip_q14(qx, nx, clipped);
            res.y_position = clip_q14(qy, ny, clipped);
            res.off_angle = r[15:0];
            res.saturated = clipped;
            return res;
        end
    endfunction

    // Receiver: random stalls, optional long hold-off, checks each transfer
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && pop && !empty) begin
            if (angle_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %h", o_result);
            end else begin
                exp_res = angle_queue.pop_front();
                if (o_result.x_position !== exp_res.x_position ||
                    o_result.y_position !== exp_res.y_position ||
                    o_result.off_angle !== exp_res.off_angle ||
                    o_result.zero_sum !== exp_res.zero_sum ||
                    o_result.saturated !== exp_res.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %h actual %h", exp_res, o_result);
                end
            end
        end
    end

    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                pop <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 12);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // push stays high after a transfer until the next item or a drain
    task automatic send_currents(input t_in_item it);
        begin
            if (idle_enable && $urandom_range(0, 9) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_item <= it;
            push <= 1'b1;
            do @(posedge i_clk); while (full);
            angle_queue.push_back(predict_sun_angle(it));
        end
    endtask

    task automatic wait_drained();
        int guard;
        begin
            guard = 0;
            push <= 1'b0;
            while (angle_queue.size() != 0 && guard < 200000) begin
                @(posedge i_clk);
                guard++;
            end
            repeat (DrainCycles) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= value;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            case (idx)
                REG_WEIGHT_ONE:   sensor_cfg.w1 = value;
                REG_WEIGHT_TWO:   sensor_cfg.w2 = value;
                REG_WEIGHT_THREE: sensor_cfg.w3 = value;
                REG_WEIGHT_FOUR:  sensor_cfg.w4 = value;
                default:          sensor_cfg.gain = value;
            endcase
        end
    endtask

    function automatic t_in_item random_currents();
        t_in_item it;
        begin
            it = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0: it.current_one = $urandom_range(0, 15);
                1: it = it & {4{16'h00FF}};
                2: it.current_three = 16'hFFFF;
                default: ;
            endcase
            return it;
        end
    endfunction

    task automatic test_directed_extremes();
        begin
            send_currents('0);
            send_currents({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
            send_currents({16'hFFFF, 16'h0, 16'h0, 16'h0});
            send_currents({16'h0, 16'hFFFF, 16'h0, 16'h0});
            send_currents({16'h0, 16'h0, 16'hFFFF, 16'h0});
            send_currents({16'h0, 16'h0, 16'h0, 16'hFFFF});
            send_currents({16'h1, 16'h0, 16'h0, 16'h0});
            send_currents({16'h1, 16'h1, 16'h0, 16'h0});
            send_currents({16'h0, 16'h1, 16'h1, 16'h0});
            send_currents({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
            wait_drained();
        end
    endtask

    task automatic test_config_extremes();
        begin
            // maximum weights one and two, zero weights three and four and maximum gain drive saturation
            write_reg(REG_WEIGHT_ONE, 16'hFFFF);
            write_reg(REG_WEIGHT_TWO, 16'hFFFF);
            write_reg(REG_WEIGHT_THREE, 16'h0);
            write_reg(REG_WEIGHT_FOUR, 16'h0);
            write_reg(REG_GAIN, 16'hFFFF);
            send_currents({16'h0, 16'hFFFF, 16'h0, 16'h0});
            send_currents({16'hFFFF, 16'h0, 16'h0, 16'h0});
            send_currents({16'h0, 16'h0, 16'h1, 16'h0});
            send_currents({16'h1, 16'h1, 16'h1, 16'h1});
            send_currents('0);
            wait_drained();
            // zero gain gives zero x, y and angle
            write_reg(REG_GAIN, 16'h0);
            send_currents({16'h1234, 16'h0, 16'h9, 16'hFFFF});
            send_currents({16'hFFFF, 16'hFFFF, 16'h0, 16'h0});
            wait_drained();
        end
    endtask

    task automatic test_random_phase(input int count);
        begin
            write_reg(REG_WEIGHT_ONE, 16'($urandom));
            write_reg(REG_WEIGHT_TWO, 16'($urandom_range(8192, 32768)));
            write_reg(REG_WEIGHT_THREE, 16'($urandom));
            write_reg(REG_WEIGHT_FOUR, 16'($urandom_range(8192, 32768)));
            write_reg(REG_GAIN, 16'($urandom));
            repeat (count) send_currents(random_currents());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        begin
            // long receiver hold-off fills the block and stalls push
            hold_cycles = 600;
            repeat (12) send_currents(random_currents());
            wait_drained();
        end
    endtask

    task automatic test_unit_no_idle(input int count);
        begin
            idle_enable = 0;
            write_reg(REG_WEIGHT_ONE, 16'd16384);
            write_reg(REG_WEIGHT_TWO, 16'd16384);
            write_reg(REG_WEIGHT_THREE, 16'd16384);
            write_reg(REG_WEIGHT_FOUR, 16'd16384);
            write_reg(REG_GAIN, 16'd4096);
            repeat (count) send_currents(random_currents());
            wait_drained();
        end
    endtask

    initial begin
        sensor_cfg = '{w1: 16'd16384, w2: 16'd16384, w3: 16'd16384, w4: 16'd16384,
                       gain: 16'd4096};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_config_extremes();
        for (int p = 0; p < 6; p++)
            test_random_phase(130);
        test_backpressure();
        test_unit_no_idle(100);
        if (mismatch_count == 0 && angle_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qdsa_pkg.sv
hdl/qdsa_front.sv
hdl/qdsa_back.sv
hdl/quad_diode_sun_angle_core.sv
tb/sv/quad_diode_sun_angle_core_tb.sv
